@@ hdl/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL; they sample on clock and hold off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/mmps_pkg.sv @@
// Types, codes and reset values shared by the process scheduler modules.
package mmps_pkg;

   typedef enum logic [1:0] {
      ACT_SCHEDULE  = 2'd0,
      ACT_EXIT      = 2'd1,
      ACT_SET_SHARE = 2'd2,
      ACT_SET_PRIO  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_RR     = 2'd0,
      MODE_LOWEST = 2'd1,
      MODE_PRIO   = 2'd2,
      MODE_SHARE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_EMPTY    = 2'd0,
      ST_RUNNABLE = 2'd1,
      ST_ENDED    = 2'd2
   } status_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  value;
   } req_type;

   typedef struct packed {
      logic [2:0]  next_slot;
      logic        idle;
   } rsp_type;

   // One stored row per process slot.
   typedef struct packed {
      status_type  status;
      logic [7:0]  prio;
      logic [7:0]  share;
      logic [7:0]  used;
   } row_type;

   // Decision of the compare unit for one visited slot.
   typedef struct packed {
      logic        hit;
      logic        take;
      logic        wr_en;
      logic [7:0]  wr_used;
   } pick_type;

   localparam int unsigned PRIO_INIT_DEPTH = 5;
   localparam logic [7:0] PRIO_INIT [PRIO_INIT_DEPTH] = '{8'd0, 8'd2, 8'd1, 8'd1, 8'd0};

   // Contents of a slot row that has never been written since reset.
   function automatic row_type reset_row(input int unsigned slot);
      row_type row;
      row.status = (slot == 0) ? ST_EMPTY : ST_RUNNABLE;
      row.prio   = (slot < PRIO_INIT_DEPTH) ? PRIO_INIT[3'(slot)] : 8'd0;
      row.share  = 8'(slot);
      row.used   = 8'd0;
      return row;
   endfunction

endpackage

@@ hdl/mmps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mmps_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 5
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mmps_slot_store.sv @@
// Per-slot state store: RAM rows plus written flags that stand in for the reset contents.
module mmps_slot_store #(
   parameter int PROCESS_SLOTS = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(PROCESS_SLOTS)-1:0]  rd_addr,
   output mmps_pkg::row_type                 rd_row,
   input  logic                              wr_en,
   input  logic [$clog2(PROCESS_SLOTS)-1:0]  wr_addr,
   input  mmps_pkg::row_type                 wr_row
);
   import mmps_pkg::*;

   localparam int SW = $clog2(PROCESS_SLOTS);
   localparam int RW = $bits(row_type);

   logic [PROCESS_SLOTS-1:0] written_ff;
   logic                     rd_written_ff;
   logic [SW-1:0]            rd_addr_ff;
   logic [RW-1:0]            ram_rd_data;

   mmps_ram #(
      .WIDTH (RW),
      .DEPTH (PROCESS_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (RW'(wr_row)),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_written_ff <= written_ff[rd_addr];
      rd_addr_ff    <= rd_addr;
   end

   // A row never written since reset reads as its reset contents.
   assign rd_row = rd_written_ff ? row_type'(ram_rd_data) : reset_row(32'(rd_addr_ff));

endmodule

@@ hdl/mmps_pick_unit.sv @@
// Shared compare unit: judges one visited slot row under the active scheduling mode.
module mmps_pick_unit (
   input  mmps_pkg::mode_type  mode,
   input  mmps_pkg::row_type   row,
   input  logic                found,
   input  logic [7:0]          best_prio,
   output mmps_pkg::pick_type  pick
);
   import mmps_pkg::*;

   logic runnable;

   assign runnable = (row.status == ST_RUNNABLE);

   always_comb begin
      pick = '0;
      case (mode)
         MODE_RR, MODE_LOWEST: begin
            pick.hit = runnable;
         end
         MODE_PRIO: begin
            // Ties go to the later slot in walk order.
            pick.take = runnable && (!found || (row.prio <= best_prio));
         end
         MODE_SHARE: begin
            pick.wr_en = 1'b1;
            if (runnable && (row.used < row.share)) begin
               pick.hit     = 1'b1;
               pick.wr_used = row.used + 8'd1;
            end else begin
               pick.wr_used = 8'd0;
            end
         end
         default: begin
            pick = '0;
         end
      endcase
   end

endmodule

@@ hdl/multi_mode_process_scheduler_unit.sv @@
// Process scheduler top level: item handshakes, configuration and the slot-walk sequencer.
//
// An item on the req channel (action, value) is taken when req_valid and req_ready are
// both high. Each item yields exactly one rsp item (next_slot, idle), held in an output
// register until rsp_ready takes it. The always-ready csr channel writes the scheduling
// mode; the user must write it only while no item is in flight, unchecked by the block.
// A schedule item walks the slots through one shared compare unit, one slot per cycle,
// behind a registered RAM read, visiting PROCESS_SLOTS slots (2 * PROCESS_SLOTS in
// proportional share mode), fewer when the walk stops at a hit. Exit adds a
// read-modify-write of the current row before the walk; set share and set priority do
// only that read-modify-write. The single RAM read port sets the walk rate, and the
// block takes one item at a time: req_ready is high only between items.
// Reset (synchronous) restores the mode to priority, the current slot to 1 and all slot
// rows to their reset contents at once through per-row written flags; no clearing pass.
// If the receiver stalls, a finished item waits in the output register and the next
// item may be accepted; its result waits until the register is free.
`include "assert_macros.svh"

module multi_mode_process_scheduler_unit #(
   parameter int PROCESS_SLOTS = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mmps_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mmps_pkg::rsp_type  rsp_payload,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_data
);
   import mmps_pkg::*;

   localparam int SW = $clog2(PROCESS_SLOTS);
   localparam int CW = $clog2(2 * PROCESS_SLOTS + 1);
   localparam logic [SW-1:0] SLOT_LAST = SW'(PROCESS_SLOTS - 1);
   localparam logic [CW-1:0] LEN_WALK  = CW'(PROCESS_SLOTS);
   localparam logic [CW-1:0] LEN_SHARE = CW'(2 * PROCESS_SLOTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_CUR,
      S_MODIFY,
      S_WALK,
      S_DONE
   } state_type;

   state_type   state_ff, state_in;
   mode_type    mode_ff;
   action_type  action_ff, action_in;
   logic [7:0]  value_ff, value_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic [SW-1:0] iss_slot_ff, iss_slot_in;
   logic [CW-1:0] iss_cnt_ff, iss_cnt_in;
   logic [CW-1:0] walk_len_ff, walk_len_in;
   logic        ev_vld_ff, ev_vld_in;
   logic [SW-1:0] ev_slot_ff, ev_slot_in;
   logic        ev_last_ff, ev_last_in;
   logic        found_ff, found_in;
   logic [7:0]  best_prio_ff, best_prio_in;
   logic [SW-1:0] best_slot_ff, best_slot_in;
   logic        res_idle_ff, res_idle_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_payload_ff, rsp_payload_in;

   logic [SW-1:0] st_rd_addr;
   row_type     st_rd_row;
   logic        st_wr_en;
   logic [SW-1:0] st_wr_addr;
   row_type     st_wr_row;
   pick_type    pick;
   logic        fin_found;
   logic [SW-1:0] fin_slot;

   mmps_slot_store #(
      .PROCESS_SLOTS (PROCESS_SLOTS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (st_rd_addr),
      .rd_row  (st_rd_row),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_row  (st_wr_row)
   );

   mmps_pick_unit u_pick (
      .mode      (mode_ff),
      .row       (st_rd_row),
      .found     (found_ff),
      .best_prio (best_prio_ff),
      .pick      (pick)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign fin_found = pick.take || found_ff;
   assign fin_slot  = pick.take ? ev_slot_ff : best_slot_ff;

   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      value_in       = value_ff;
      cur_in         = cur_ff;
      iss_slot_in    = iss_slot_ff;
      iss_cnt_in     = iss_cnt_ff;
      walk_len_in    = walk_len_ff;
      ev_vld_in      = 1'b0;
      ev_slot_in     = ev_slot_ff;
      ev_last_in     = ev_last_ff;
      found_in       = found_ff;
      best_prio_in   = best_prio_ff;
      best_slot_in   = best_slot_ff;
      res_idle_in    = res_idle_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      st_rd_addr     = iss_slot_ff;
      st_wr_en       = 1'b0;
      st_wr_addr     = ev_slot_ff;
      st_wr_row      = st_rd_row;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               action_in  = req_payload.action;
               value_in   = req_payload.value;
               iss_cnt_in = '0;
               found_in   = 1'b0;
               case (mode_ff)
                  MODE_RR: begin
                     iss_slot_in = (cur_ff == SLOT_LAST) ? '0 : cur_ff + SW'(1);
                     walk_len_in = LEN_WALK;
                  end
                  MODE_LOWEST: begin
                     iss_slot_in = SW'(1);
                     walk_len_in = LEN_WALK;
                  end
                  MODE_SHARE: begin
                     iss_slot_in = cur_ff;
                     walk_len_in = LEN_SHARE;
                  end
                  default: begin
                     iss_slot_in = cur_ff;
                     walk_len_in = LEN_WALK;
                  end
               endcase
               state_in = (req_payload.action == ACT_SCHEDULE) ? S_WALK : S_READ_CUR;
            end
         end
         S_READ_CUR: begin
            st_rd_addr = cur_ff;
            state_in   = S_MODIFY;
         end
         S_MODIFY: begin
            // Read-modify-write of the current row; an ended slot still takes new values.
            st_wr_en   = 1'b1;
            st_wr_addr = cur_ff;
            case (action_ff)
               ACT_SET_SHARE: begin
                  st_wr_row.share = value_ff;
                  res_idle_in     = 1'b0;
                  state_in        = S_DONE;
               end
               ACT_SET_PRIO: begin
                  st_wr_row.prio = value_ff;
                  res_idle_in    = 1'b0;
                  state_in       = S_DONE;
               end
               ACT_EXIT: begin
                  st_wr_row.status = ST_ENDED;
                  state_in         = S_WALK;
               end
               default: begin
                  st_wr_en = 1'b0;
                  state_in = S_WALK;
               end
            endcase
         end
         S_WALK: begin
            // Issue the read of the next slot while the previous one is judged.
            if (iss_cnt_ff != walk_len_ff) begin
               ev_vld_in   = 1'b1;
               ev_slot_in  = iss_slot_ff;
               ev_last_in  = (iss_cnt_ff == walk_len_ff - CW'(1));
               iss_slot_in = (iss_slot_ff == SLOT_LAST) ? '0 : iss_slot_ff + SW'(1);
               iss_cnt_in  = iss_cnt_ff + CW'(1);
            end
            if (ev_vld_ff) begin
               if (pick.wr_en) begin
                  st_wr_en       = 1'b1;
                  st_wr_row.used = pick.wr_used;
               end
               if (pick.take) begin
                  found_in     = 1'b1;
                  best_prio_in = st_rd_row.prio;
                  best_slot_in = ev_slot_ff;
               end
               if (pick.hit) begin
                  cur_in      = ev_slot_ff;
                  res_idle_in = 1'b0;
                  ev_vld_in   = 1'b0;
                  state_in    = S_DONE;
               end else if (ev_last_ff) begin
                  if (fin_found) begin
                     cur_in = fin_slot;
                  end
                  res_idle_in = !fin_found;
                  ev_vld_in   = 1'b0;
                  state_in    = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.next_slot = 3'(cur_ff);
               rsp_payload_in.idle      = res_idle_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_PRIO;
         cur_ff       <= SW'(1);
         ev_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         ev_vld_ff    <= ev_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= mode_type'(csr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      value_ff       <= value_in;
      iss_slot_ff    <= iss_slot_in;
      iss_cnt_ff     <= iss_cnt_in;
      walk_len_ff    <= walk_len_in;
      ev_slot_ff     <= ev_slot_in;
      ev_last_ff     <= ev_last_in;
      found_ff       <= found_in;
      best_prio_ff   <= best_prio_in;
      best_slot_ff   <= best_slot_in;
      res_idle_ff    <= res_idle_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   `ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   `ASSERT_HOLDS(a_cur_in_range, cur_ff <= SLOT_LAST)
   `ASSERT_IMPLIES(a_walk_write_share, st_wr_en && (state_ff == S_WALK), mode_ff == MODE_SHARE)
   `ASSERT_IMPLIES(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == S_DONE)

endmodule
